[rtl/core/nsf_pkg.sv]
// nsf_pkg: shared widths and register indexes for the substring finder
// used by the channel interfaces and the top level; no dependencies
`timescale 1ns / 1ps

package nsf_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int KEY_BITS   = 64;
    localparam int SIZE_BITS  = 4;
    localparam int COUNT_BITS = 32;
    localparam int START_BITS = 32;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_KEY_BYTES = 1'b0,
        CFG_KEY_SIZE  = 1'b1
    } cfg_index_t;

endpackage

[rtl/core/nsf_if.sv]
// nsf_in_if / nsf_out_if: valid/ready channels for text bytes and match results
// depends on nsf_pkg for field widths
`timescale 1ns / 1ps

interface nsf_in_if;
    logic                          valid;
    logic                          ready;
    logic [nsf_pkg::BYTE_BITS-1:0] text_byte;
    logic                          final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface nsf_out_if;
    logic                           valid;
    logic                           ready;
    logic                           match_found;
    logic [nsf_pkg::START_BITS-1:0] match_start;
    logic [nsf_pkg::COUNT_BITS-1:0] match_total;
    logic                           text_done;

    modport source (output valid, output match_found, output match_start,
                    output match_total, output text_done, input ready);
    modport sink   (input valid, input match_found, input match_start,
                    input match_total, input text_done, output ready);
endinterface

[rtl/core/nonoverlap_substring_finder.sv]
// nonoverlap_substring_finder: streaming leftmost non-overlapping key search
// depends on nsf_pkg and the channel interfaces in nsf_if.sv
`timescale 1ns / 1ps
//
// usage
//   in_ch carries one text byte per transaction, with final_byte marking the
//   last byte of a text. out_ch carries one result transaction for every byte
//   at which a match ends or that is final; other bytes give no result.
//   the key (key_bytes, index 0) and its length (key_size, index 1) are set
//   through the write port cfg_we / cfg_index / cfg_data while the block idles.
// timing
//   a result appears on out_ch in the cycle after its byte is taken. one byte
//   is taken every cycle while no result stalls; the window compare and counter
//   updates sit between the state registers and the single output register.
// reset
//   rst_n clears the position, holdoff and match counters, empties the output
//   register and sets key_size to 1 and the key to zero.
// stall
//   while a result waits and out_ch.ready is low, in_ch.ready is low; as soon
//   as the result is taken a new byte may enter in the same cycle.
//
module nonoverlap_substring_finder #(
    parameter int MAX_KEY_BYTES = 8,
    parameter int POSITION_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nsf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nsf_pkg::KEY_BITS-1:0]      cfg_data,
    nsf_in_if.sink                            in_ch,
    nsf_out_if.source                         out_ch
);

    localparam int SUB_BITS = (POSITION_BITS > nsf_pkg::START_BITS)
                              ? POSITION_BITS : nsf_pkg::START_BITS;
    localparam logic [nsf_pkg::SIZE_BITS-1:0] MAX_SIZE =
        nsf_pkg::SIZE_BITS'(MAX_KEY_BYTES);

    // configuration
    logic [nsf_pkg::KEY_BITS-1:0]  key_reg;
    logic [nsf_pkg::SIZE_BITS-1:0] key_size_reg;

    // text state
    logic [nsf_pkg::BYTE_BITS-1:0] recent_reg [MAX_KEY_BYTES];
    logic [POSITION_BITS-1:0]      bytes_seen_reg, bytes_seen_next;
    logic [nsf_pkg::SIZE_BITS-1:0] holdoff_reg, holdoff_next;
    logic [nsf_pkg::COUNT_BITS-1:0] found_count_reg, found_count_next;

    // output register
    logic                            out_valid_reg;
    logic                            out_found_reg;
    logic [nsf_pkg::START_BITS-1:0]  out_start_reg;
    logic [nsf_pkg::COUNT_BITS-1:0]  out_total_reg;
    logic                            out_done_reg;

    logic                            in_fire;
    logic                            out_fire;
    logic [nsf_pkg::BYTE_BITS-1:0]   win [MAX_KEY_BYTES];
    logic [MAX_KEY_BYTES-1:0]        size_match;
    logic [nsf_pkg::SIZE_BITS-1:0]   eff_size;
    logic [nsf_pkg::SIZE_BITS-1:0]   eff_size_m1;
    logic                            window_hit;
    logic                            hit;
    logic [SUB_BITS-1:0]             start_wide;
    logic                            emit;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_valid_reg && out_ch.ready;

    // effective key length, clamped to 1..MAX_KEY_BYTES
    always_comb
    begin
        if (key_size_reg == '0)
        begin
            eff_size = nsf_pkg::SIZE_BITS'(1);
        end
        else if (key_size_reg > MAX_SIZE)
        begin
            eff_size = MAX_SIZE;
        end
        else
        begin
            eff_size = key_size_reg;
        end
    end

    assign eff_size_m1 = eff_size - nsf_pkg::SIZE_BITS'(1);

    // window, newest byte first
    always_comb
    begin
        win[0] = in_ch.text_byte;
        for (int i = 1; i < MAX_KEY_BYTES; i++)
        begin
            win[i] = recent_reg[i-1];
        end
    end

    // one compare set per candidate key length
    always_comb
    begin
        for (int kk = 1; kk <= MAX_KEY_BYTES; kk++)
        begin
            size_match[kk-1] = 1'b1;
            for (int j = 0; j < kk; j++)
            begin
                if (win[kk-1-j] != key_reg[nsf_pkg::BYTE_BITS*j +: nsf_pkg::BYTE_BITS])
                begin
                    size_match[kk-1] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        window_hit = 1'b0;
        for (int kk = 1; kk <= MAX_KEY_BYTES; kk++)
        begin
            if (eff_size == nsf_pkg::SIZE_BITS'(kk))
            begin
                window_hit = size_match[kk-1];
            end
        end
    end

    assign hit = (holdoff_reg == '0)
              && (bytes_seen_reg >= POSITION_BITS'(eff_size_m1))
              && window_hit;

    assign start_wide = SUB_BITS'(bytes_seen_reg) - SUB_BITS'(eff_size_m1);
    assign emit       = hit || in_ch.final_byte;

    always_comb
    begin
        if (holdoff_reg != '0)
        begin
            holdoff_next = holdoff_reg - nsf_pkg::SIZE_BITS'(1);
        end
        else if (hit)
        begin
            holdoff_next = eff_size_m1;
        end
        else
        begin
            holdoff_next = holdoff_reg;
        end

        if (hit && (found_count_reg != '1))
        begin
            found_count_next = found_count_reg + nsf_pkg::COUNT_BITS'(1);
        end
        else
        begin
            found_count_next = found_count_reg;
        end

        if (bytes_seen_reg != '1)
        begin
            bytes_seen_next = bytes_seen_reg + POSITION_BITS'(1);
        end
        else
        begin
            bytes_seen_next = bytes_seen_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            key_size_reg <= nsf_pkg::SIZE_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (nsf_pkg::cfg_index_t'(cfg_index))
                nsf_pkg::CFG_KEY_BYTES: key_reg      <= cfg_data;
                nsf_pkg::CFG_KEY_SIZE:  key_size_reg <= cfg_data[nsf_pkg::SIZE_BITS-1:0];
                default:                key_reg      <= key_reg;
            endcase
        end
    end

    // text state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg  <= '0;
            holdoff_reg     <= '0;
            found_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (in_ch.final_byte)
                begin
                    bytes_seen_reg  <= '0;
                    holdoff_reg     <= '0;
                    found_count_reg <= '0;
                end
                else
                begin
                    bytes_seen_reg  <= bytes_seen_next;
                    holdoff_reg     <= holdoff_next;
                    found_count_reg <= found_count_next;
                end
            end

            if (in_fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // byte history and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < MAX_KEY_BYTES; i++)
            begin
                recent_reg[i] <= win[i];
            end
        end

        if (in_fire && emit)
        begin
            out_found_reg <= hit;
            out_start_reg <= hit ? start_wide[nsf_pkg::START_BITS-1:0] : '0;
            out_total_reg <= found_count_next;
            out_done_reg  <= in_ch.final_byte;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.match_found = out_found_reg;
    assign out_ch.match_start = out_start_reg;
    assign out_ch.match_total = out_total_reg;
    assign out_ch.text_done   = out_done_reg;

    // checks
    a_found_has_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_found_reg |-> out_total_reg != '0)
        else $error("match reported with zero total");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_ch.final_byte |=> bytes_seen_reg == '0 && found_count_reg == '0
                                        && holdoff_reg == '0)
        else $error("text state not cleared after final byte");

    a_holdoff_bound: assert property (@(posedge clk) disable iff (!rst_n)
        holdoff_reg <= MAX_SIZE - nsf_pkg::SIZE_BITS'(1))
        else $error("holdoff beyond key length");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while result stalled");

    a_no_hit_in_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && hit && !in_ch.final_byte |=> holdoff_reg == $past(eff_size_m1))
        else $error("holdoff not armed after match");

endmodule

[sim/nonoverlap_substring_finder_tb.sv]
// nonoverlap_substring_finder_tb: streams texts through the substring finder and
// checks every result against a cycle-free predictor of the key search
// depends on nsf_pkg, nsf_in_if / nsf_out_if and nonoverlap_substring_finder
`timescale 1ns / 1ps

typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic [31:0] total;
    logic        done;
} match_result_t;

class match_scoreboard;
    localparam int MAX_KEY = 8;
    localparam int MAX_REPORTS = 100;

    logic [63:0]   key_bytes;
    logic [3:0]    key_size;
    logic [7:0]    window [MAX_KEY];
    logic [31:0]   offset;
    logic [3:0]    holdoff;
    logic [31:0]   found;
    match_result_t expected_matches [$];
    int            errors;
    int            texts;
    int            match_count;
    int            settings;

    function new();
        key_bytes   = '0;
        key_size    = 4'd1;
        errors      = 0;
        texts       = 0;
        match_count = 0;
        settings    = 0;
        clear_text();
    endfunction

    function void clear_text();
        for (int i = 0; i < MAX_KEY; i++)
            window[i] = 8'h00;
        offset  = '0;
        holdoff = '0;
        found   = '0;
    endfunction

    function int unsigned eff_size();
        if (key_size == 4'd0)
            return 1;
        if (key_size > MAX_KEY)
            return MAX_KEY;
        return key_size;
    endfunction

    function void set_config(logic [63:0] key, logic [3:0] size);
        key_bytes = key;
        key_size  = size;
        settings++;
    endfunction

    function int pending();
        return expected_matches.size();
    endfunction

    // one accepted text byte: slide the window and look for a match ending here
    function void note_byte(logic [7:0] text_byte, logic final_byte);
        int unsigned   k;
        logic          hit;
        logic [31:0]   start;
        match_result_t res;
        k     = eff_size();
        hit   = 1'b0;
        start = '0;
        for (int i = MAX_KEY - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = text_byte;
        if (holdoff != 4'd0)
        begin
            holdoff = holdoff - 4'd1;
        end
        else if (offset >= k - 1)
        begin
            hit = 1'b1;
            for (int j = 0; j < k; j++)
                if (window[k-1-j] != key_bytes[8*j +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                start   = offset - (k - 1);
                holdoff = 4'(k - 1);
                if (found != '1)
                    found++;
                match_count++;
            end
        end
        if (offset != '1)
            offset++;
        if (hit || final_byte)
        begin
            res.found = hit;
            res.start = start;
            res.total = found;
            res.done  = final_byte;
            expected_matches.push_back(res);
        end
        if (final_byte)
        begin
            texts++;
            clear_text();
        end
    endfunction

    function void check_result(match_result_t got);
        match_result_t exp;
        if (expected_matches.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected result found=%0d start=%0d total=%0d done=%0d",
                         $time, got.found, got.start, got.total, got.done);
            return;
        end
        exp = expected_matches.pop_front();
        if (got.found !== exp.found || got.start !== exp.start ||
            got.total !== exp.total || got.done !== exp.done)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: mismatch expected found=%0d start=%0d total=%0d done=%0d, actual found=%0d start=%0d total=%0d done=%0d",
                         $time, exp.found, exp.start, exp.total, exp.done,
                         got.found, got.start, got.total, got.done);
        end
    endfunction
endclass

module nonoverlap_substring_finder_tb;

    localparam int ITEM_TARGET   = 1500;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;

    typedef enum int {
        RX_STREAM = 0,
        RX_RANDOM = 1,
        RX_SPARSE = 2,
        RX_HOLD   = 3
    } rx_mode_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    nsf_pkg::cfg_index_t          cfg_index;
    logic [nsf_pkg::KEY_BITS-1:0] cfg_data;

    nsf_in_if  in_if ();
    nsf_out_if out_if ();

    match_scoreboard sb = new();

    int  bytes_taken;
    int  results_taken;
    int  stall_cycles;
    int  burst_left;
    bit  long_hold_done;

    nonoverlap_substring_finder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_if),
        .out_ch   (out_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // input and output transaction monitors
    always @(posedge clk)
    begin
        if (rst_n && in_if.valid && in_if.ready)
        begin
            sb.note_byte(in_if.text_byte, in_if.final_byte);
            bytes_taken++;
        end
    end

    always @(posedge clk)
    begin
        match_result_t got;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got.found = out_if.match_found;
            got.start = out_if.match_start;
            got.total = out_if.match_total;
            got.done  = out_if.text_done;
            sb.check_result(got);
            results_taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: stall pattern picked per stretch, with at least one long hold
    initial
    begin
        rx_mode_t mode;
        int       span;
        mode = RX_STREAM;
        span = 0;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                if (!long_hold_done && rst_n && in_if.valid)
                begin
                    mode = RX_HOLD;
                    span = $urandom_range(60, 120);
                    long_hold_done = 1'b1;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    mode = RX_HOLD;
                    span = $urandom_range(20, 60);
                end
                else
                begin
                    mode = rx_mode_t'($urandom_range(RX_STREAM, RX_SPARSE));
                    span = $urandom_range(8, 60);
                end
            end
            span--;
            case (mode)
                RX_STREAM: out_if.ready <= 1'b1;
                RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                default:   out_if.ready <= 1'b0;
            endcase
        end
    end

    task automatic drive_byte(input logic [7:0] text_byte, input logic final_byte);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_if.valid      <= 1'b1;
        in_if.text_byte  <= text_byte;
        in_if.final_byte <= final_byte;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
    endtask

    task automatic send_text(input logic [7:0] text_q [$], input bit terminate);
        for (int i = 0; i < text_q.size(); i++)
            drive_byte(text_q[i], terminate && (i == text_q.size() - 1));
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [63:0] key, input logic [3:0] size);
        cfg_we    <= 1'b1;
        cfg_index <= nsf_pkg::CFG_KEY_BYTES;
        cfg_data  <= key;
        @(posedge clk);
        cfg_index <= nsf_pkg::CFG_KEY_SIZE;
        cfg_data  <= {60'd0, size};
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(key, size);
    endtask

    initial
    begin
        logic [7:0]  text_q [$];
        logic [63:0] key;
        logic [7:0]  sym_a;
        logic [7:0]  sym_b;
        logic [3:0]  size;
        int          k;
        int          len;
        int          n_texts;
        int          r;
        int          pick;
        bit          terminate;

        bytes_taken      = 0;
        results_taken    = 0;
        stall_cycles     = 0;
        burst_left       = 0;
        long_hold_done   = 1'b0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= nsf_pkg::CFG_KEY_BYTES;
        cfg_data         <= '0;
        in_if.valid      <= 1'b0;
        in_if.text_byte  <= '0;
        in_if.final_byte <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key is a single zero byte
        text_q = {8'h00, 8'hFF};
        send_text(text_q, 1'b1);
        wait_idle();

        // size zero acts as one
        write_config(64'h0000_0000_0000_00FF, 4'd0);
        text_q = {8'hFF};
        send_text(text_q, 1'b1);
        wait_idle();

        // oversized length acts as eight; then a text shorter than the key
        write_config('1, 4'd15);
        text_q.delete();
        repeat (9) text_q.push_back(8'hFF);
        send_text(text_q, 1'b1);
        text_q = {8'hFF, 8'hFF, 8'hFF};
        send_text(text_q, 1'b1);
        wait_idle();

        // self-overlapping key with junk in the unused upper bytes, left open
        write_config(64'h5a5a_5a5a_5a61_6261, 4'd3);
        text_q = {8'h61, 8'h62, 8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
        send_text(text_q, 1'b0);
        wait_idle();

        // key change in the middle of a text while a holdoff is pending
        write_config(64'h0000_0000_0000_0062, 4'd1);
        text_q = {8'h62};
        send_text(text_q, 1'b1);
        wait_idle();

        while (bytes_taken < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                size = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
            else
                size = 4'($urandom_range(1, 8));
            case ($urandom_range(0, 3))
                0: key = {$urandom, $urandom};
                1:
                begin
                    sym_a = 8'($urandom);
                    sym_b = 8'($urandom);
                    for (int j = 0; j < 8; j++)
                        key[8*j +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
                end
                2:
                begin
                    pick  = $urandom_range(0, 2);
                    sym_a = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
                    key   = {8{sym_a}};
                end
                default: key = $urandom_range(0, 1) ? 64'd0 : '1;
            endcase
            write_config(key, size);
            k = sb.eff_size();

            n_texts = $urandom_range(1, 6);
            for (int t = 0; t < n_texts; t++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 40);
                text_q.delete();
                while (text_q.size() < len)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 4)
                    begin
                        for (int j = 0; j < k; j++)
                            text_q.push_back(key[8*j +: 8]);
                    end
                    else if (r < 8)
                    begin
                        pick = $urandom_range(0, k - 1);
                        text_q.push_back(key[8*pick +: 8]);
                    end
                    else
                    begin
                        text_q.push_back(8'($urandom));
                    end
                end
                terminate = (t != n_texts - 1) || ($urandom_range(0, 3) != 0);
                send_text(text_q, terminate);
            end
            wait_idle();
        end

        $display("run covered %0d text bytes in %0d texts under %0d key settings,",
                 bytes_taken, sb.texts, sb.settings);
        $display("with %0d matches among %0d result transactions", sb.match_count,
                 results_taken);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
